@@ design/bgms_pkg.sv @@
// shared types and constants for the binary grid majority smoothing block
package bgms_pkg;

   // row and result field widths
   localparam int ROW_W         = 64;
   localparam int OUT_ROW_W     = 10;
   localparam int RSP_TDATA_W   = 80;
   localparam int GRID_WIDTH_W  = 7;
   localparam int GRID_HEIGHT_W = 11;
   localparam int RULE_MODE_W   = 1;

   // csr port
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 11;

   localparam logic [CSR_IDX_W-1:0] CSR_GRID_WIDTH  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_GRID_HEIGHT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_RULE_MODE   = 2'd2;

   localparam logic [GRID_WIDTH_W-1:0]  GRID_WIDTH_RST  = 7'd64;
   localparam logic [GRID_HEIGHT_W-1:0] GRID_HEIGHT_RST = 11'd64;
   localparam logic [RULE_MODE_W-1:0]   RULE_MODE_RST   = 1'b1;

   // smallest frame: top border, one interior row, bottom border
   localparam logic [GRID_HEIGHT_W-1:0] MIN_HEIGHT = 11'd3;

   // 3x3 neighborhood
   localparam int NBHD_W     = 9;
   localparam int NBHD_CNT_W = 4;
   localparam logic [NBHD_CNT_W-1:0] WALL_MAJORITY    = 4'd4;
   localparam logic [NBHD_CNT_W-1:0] WALL_EMPTY_BELOW = 4'd1;

   typedef struct packed {
      logic                 frame_end;
      logic [OUT_ROW_W-1:0] out_row;
      logic [ROW_W-1:0]     out_cells;
   } rsp_item_type;

   // up to two results pushed per request
   typedef struct packed {
      logic         first_valid;
      logic         second_valid;
      rsp_item_type first;
      rsp_item_type second;
   } fifo_wr_type;

endpackage

@@ design/bgms_lane.sv @@
// one cell of the smoothing rule: 3x3 wall count and threshold
module bgms_lane
   import bgms_pkg::*;
(
   input  logic [NBHD_W-1:0] nbhd,
   input  logic              rule_mode,
   output logic              wall
);

   logic [NBHD_CNT_W-1:0] count;

   always_comb begin
      count = '0;
      for (int i = 0; i < NBHD_W; i++) begin
         count = count + NBHD_CNT_W'(nbhd[i]);
      end
      wall = (count > WALL_MAJORITY) || (rule_mode && (count < WALL_EMPTY_BELOW));
   end

endmodule

@@ design/bgms_row_filter.sv @@
// row of smoothing lanes and the merge with pass-through border cells
module bgms_row_filter
   import bgms_pkg::*;
#(
   parameter int MAX_WIDTH = 64
) (
   input  logic [ROW_W-1:0]        above,
   input  logic [ROW_W-1:0]        mid,
   input  logic [ROW_W-1:0]        below,
   input  logic [GRID_WIDTH_W-1:0] width_eff,
   input  logic                    rule_mode,
   output logic [ROW_W-1:0]        row_out
);

   localparam int LAST_LANE = MAX_WIDTH - 2;

   logic [ROW_W-1:0] lane_wall;
   logic [ROW_W-1:0] interior;

   // lanes exist only where a column can be interior
   for (genvar c = 1; c <= LAST_LANE; c++) begin : g_lane
      bgms_lane u_lane (
         .nbhd      ({above[c+1:c-1], mid[c+1:c-1], below[c+1:c-1]}),
         .rule_mode (rule_mode),
         .wall      (lane_wall[c])
      );
      assign interior[c] = GRID_WIDTH_W'(c + 1) < width_eff;
   end

   assign lane_wall[0] = 1'b0;
   assign interior[0]  = 1'b0;
   for (genvar c = LAST_LANE + 1; c < ROW_W; c++) begin : g_edge
      assign lane_wall[c] = 1'b0;
      assign interior[c]  = 1'b0;
   end

   // merge: interior cells from the lanes, everything else unchanged
   assign row_out = (lane_wall & interior) | (mid & ~interior);

endmodule

@@ design/bgms_rsp_fifo.sv @@
// small result queue, takes up to two results a cycle and gives one
module bgms_rsp_fifo
   import bgms_pkg::*;
#(
   parameter int DEPTH = 4
) (
   input  logic         clock,
   input  logic         reset,
   input  fifo_wr_type  wr,
   output logic         room,
   input  logic         pop,
   output logic         rd_valid,
   output rsp_item_type rd_item
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   rsp_item_type     mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [PTR_W-1:0] wr_ptr_next;
   logic             do_pop;

   assign rd_valid    = count_ff != '0;
   assign rd_item     = mem_ff[rd_ptr_ff];
   assign room        = count_ff <= CNT_W'(DEPTH - 2);
   assign do_pop      = pop && rd_valid;
   assign wr_ptr_next = wr_ptr_ff + 1'b1;

   always_comb begin
      wr_ptr_in = wr_ptr_ff + PTR_W'(wr.first_valid) + PTR_W'(wr.second_valid);
      rd_ptr_in = rd_ptr_ff + PTR_W'(do_pop);
      count_in  = count_ff + CNT_W'(wr.first_valid) + CNT_W'(wr.second_valid)
                  - CNT_W'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr.first_valid) begin
         mem_ff[wr_ptr_ff] <= wr.first;
      end
      if (wr.second_valid) begin
         mem_ff[wr_ptr_next] <= wr.second;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      (wr.first_valid || wr.second_valid) |-> room)
      else $error("result queue written without room");

   a_second_after_first: assert property (@(posedge clock) disable iff (reset)
      wr.second_valid |-> wr.first_valid)
      else $error("second result pushed alone");

   a_drain_empties: assert property (@(posedge clock) disable iff (reset)
      (count_ff == CNT_W'(1) && do_pop && !wr.first_valid) |=> !rd_valid)
      else $error("queue not empty after last pop");

endmodule

@@ design/binary_grid_majority_smoothing.sv @@
// top level: row window, lane filter and result queue for cave smoothing
//
//  channel  dir  accepted when            payload
//  req_     in   req_tvalid & req_tready  tdata[63:0] row_cells
//  rsp_     out  rsp_tvalid & rsp_tready  tdata[63:0] out_cells, [73:64] out_row,
//                                         tlast frame_end
//  csr_     in   csr_we                   csr_index selects register, csr_wdata
//
// one request per cycle while req_tready is high; a request goes through the combinational
// lane filter into the registered result queue, so its first result can leave the cycle after
// reset clears the row counter and the queue; no clearing pass is needed
// the final row of a frame pushes two results at once into the 4-entry queue
// req_tready is high while the queue has room for two, so a stalled rsp_
// side holds back requests only once three or more results are waiting
module binary_grid_majority_smoothing
   import bgms_pkg::*;
#(
   parameter int MAX_WIDTH  = 64,
   parameter int MAX_HEIGHT = 1024
) (
   input  logic                   clock,
   input  logic                   reset,
   // request: row_cells
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [ROW_W-1:0]       req_tdata,
   // result: out_cells, out_row, zero pad
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0] rsp_tdata,
   output logic                   rsp_tlast,
   // csr write port
   input  logic                   csr_we,
   input  logic [CSR_IDX_W-1:0]   csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   localparam int CNT_W  = $clog2(MAX_HEIGHT);
   localparam int ROWX_W = (CNT_W > OUT_ROW_W) ? CNT_W : OUT_ROW_W;
   localparam int HCMP_W = (CNT_W + 1 > GRID_HEIGHT_W) ? CNT_W + 1 : GRID_HEIGHT_W;

   // configuration registers
   logic [GRID_WIDTH_W-1:0]  grid_width_ff;
   logic [GRID_HEIGHT_W-1:0] grid_height_ff;
   logic                     rule_mode_ff;

   // row window
   logic [ROW_W-1:0] older_row_ff, older_row_in;
   logic [ROW_W-1:0] newer_row_ff, newer_row_in;
   logic [CNT_W-1:0] row_count_ff, row_count_in;

   logic                    req_fire;
   logic [GRID_WIDTH_W-1:0] width_eff;
   logic [HCMP_W-1:0]       height_eff;
   logic [CNT_W-1:0]        last_row;
   logic                    is_last;
   logic [ROW_W-1:0]        smoothed;
   logic [ROWX_W-1:0]       prev_row_x;
   logic [ROWX_W-1:0]       this_row_x;
   fifo_wr_type             wr;
   rsp_item_type            rd_item;

   // csr decode
   always_ff @(posedge clock) begin
      if (reset) begin
         grid_width_ff  <= GRID_WIDTH_RST;
         grid_height_ff <= GRID_HEIGHT_RST;
         rule_mode_ff   <= RULE_MODE_RST;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_GRID_WIDTH:  grid_width_ff  <= csr_wdata[GRID_WIDTH_W-1:0];
            CSR_GRID_HEIGHT: grid_height_ff <= csr_wdata[GRID_HEIGHT_W-1:0];
            CSR_RULE_MODE:   rule_mode_ff   <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // saturate width to the lanes built and clamp height between MIN_HEIGHT and the counter range
   always_comb begin
      width_eff = (grid_width_ff > GRID_WIDTH_W'(MAX_WIDTH)) ?
                  GRID_WIDTH_W'(MAX_WIDTH) : grid_width_ff;
      if (grid_height_ff < MIN_HEIGHT) begin
         height_eff = HCMP_W'(MIN_HEIGHT);
      end else if (HCMP_W'(grid_height_ff) > HCMP_W'(MAX_HEIGHT)) begin
         height_eff = HCMP_W'(MAX_HEIGHT);
      end else begin
         height_eff = HCMP_W'(grid_height_ff);
      end
      last_row = CNT_W'(height_eff - 1'b1);
      // a counter already past a shortened frame ends it on the next row
      is_last  = row_count_ff >= last_row;
   end

   bgms_row_filter #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_filter (
      .above     (older_row_ff),
      .mid       (newer_row_ff),
      .below     (req_tdata),
      .width_eff (width_eff),
      .rule_mode (rule_mode_ff),
      .row_out   (smoothed)
   );

   assign req_fire   = req_tvalid && req_tready;
   assign prev_row_x = ROWX_W'(row_count_ff - 1'b1);
   assign this_row_x = ROWX_W'(row_count_ff);

   // results and window update for one request
   always_comb begin
      wr           = '0;
      older_row_in = older_row_ff;
      newer_row_in = newer_row_ff;
      row_count_in = row_count_ff;
      if (req_fire) begin
         if (row_count_ff == '0) begin
            // top row is only stored
            older_row_in = '0;
            newer_row_in = req_tdata;
            row_count_in = CNT_W'(1);
         end else begin
            wr.first_valid = 1'b1;
            if (row_count_ff == CNT_W'(1)) begin
               // top border row leaves unchanged
               wr.first.out_cells = newer_row_ff;
               wr.first.out_row   = '0;
            end else begin
               wr.first.out_cells = smoothed;
               wr.first.out_row   = prev_row_x[OUT_ROW_W-1:0];
            end
            wr.first.frame_end = 1'b0;
            if (is_last) begin
               // bottom border row follows at once and closes the frame
               wr.second_valid     = 1'b1;
               wr.second.out_cells = req_tdata;
               wr.second.out_row   = this_row_x[OUT_ROW_W-1:0];
               wr.second.frame_end = 1'b1;
               older_row_in        = '0;
               newer_row_in        = '0;
               row_count_in        = '0;
            end else begin
               older_row_in = newer_row_ff;
               newer_row_in = req_tdata;
               row_count_in = row_count_ff + 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_count_ff <= '0;
      end else begin
         row_count_ff <= row_count_in;
      end
   end

   always_ff @(posedge clock) begin
      older_row_ff <= older_row_in;
      newer_row_ff <= newer_row_in;
   end

   bgms_rsp_fifo #(
      .DEPTH (4)
   ) u_rsp_fifo (
      .clock    (clock),
      .reset    (reset),
      .wr       (wr),
      .room     (req_tready),
      .pop      (rsp_tready),
      .rd_valid (rsp_tvalid),
      .rd_item  (rd_item)
   );

   assign rsp_tdata = {{(RSP_TDATA_W - ROW_W - OUT_ROW_W){1'b0}},
                       rd_item.out_row, rd_item.out_cells};
   assign rsp_tlast = rd_item.frame_end;

   a_top_row_silent: assert property (@(posedge clock) disable iff (reset)
      (req_fire && row_count_ff == '0) |-> !wr.first_valid)
      else $error("result produced for the top row");

   a_frame_wraps: assert property (@(posedge clock) disable iff (reset)
      (req_fire && row_count_ff != '0 && is_last) |=> row_count_ff == '0)
      else $error("row counter did not wrap after the final row");

   a_rsp_held: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=>
         (rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast)))
      else $error("waiting result changed before it was taken");

endmodule
